[src/frls_pkg.sv]
// Package for the free range list: sizes, command codes, state type and range type.
// Used by free_range_list_subtract; has no dependencies of its own.
package frls_pkg;

    localparam int MAX_RANGES = 16;
    localparam int ADDR_BITS  = 32;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_SUB  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    typedef struct packed {
        logic [ADDR_BITS-1:0] hi;
        logic [ADDR_BITS-1:0] lo;
    } t_range;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD,
        S_EV,
        S_SH_RD,
        S_SH_WR,
        S_SPL_LO,
        S_SPL_HI,
        S_DONE
    } t_state;

endpackage

[src/frls_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module frls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/free_range_list_subtract.sv]
// Free range list with gap subtraction: top level, FSM and result register.
// Depends on frls_pkg and frls_ram.
//
// Keeps a sorted list of disjoint inclusive address ranges still uncovered inside a region,
// held in one RAM of MAX_RANGES entries (one range per entry). An init item sets the region
// and makes the list that single range; a subtract item clamps the gap to the region and
// walks the list, dropping covered ranges, trimming overlapped ones, or splitting the one
// range that strictly holds the gap; a read item returns one entry. Every item gives exactly
// one result, carrying the range count. One item is in work at a time. Init and read pass
// the check state, then load their result into the output register from the done state;
// the next item is accepted in idle. A subtract passes the check state, a RAM read state
// and an evaluate state per list entry walked (evaluate writes back through the single
// write port), a read and a write state per entry moved up when a split opens a slot, the
// two split writes, the done state that hands over the result once the output register is
// free, and idle to accept the next item. Entries walked plus entries moved never exceed
// MAX_RANGES. A finished result sits in an output register, so the next item is accepted
// while the previous result still waits to be taken.
module free_range_list_subtract (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_cmd,
    input  logic [frls_pkg::ADDR_BITS-1:0] i_gap_start,
    input  logic [frls_pkg::ADDR_BITS-1:0] i_gap_end,
    input  logic [frls_pkg::IDX_W-1:0]    i_entry_index,
    // result item channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [frls_pkg::CNT_W-1:0]    o_range_count,
    output logic                          o_entry_valid,
    output logic [frls_pkg::ADDR_BITS-1:0] o_entry_start,
    output logic [frls_pkg::ADDR_BITS-1:0] o_entry_end,
    output logic                          o_overflow
);
    import frls_pkg::*;

    // FSM and item state
    t_state               r_state, n_state;
    logic [1:0]           r_cmd, n_cmd;
    logic [ADDR_BITS-1:0] r_gs, n_gs;
    logic [ADDR_BITS-1:0] r_ge, n_ge;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [ADDR_BITS-1:0] r_region_lo, n_region_lo;
    logic [ADDR_BITS-1:0] r_region_hi, n_region_hi;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_rd, n_rd;       // walk read position
    logic [CNT_W-1:0]     r_wr, n_wr;       // walk write position (compaction)
    logic [IDX_W-1:0]     r_j, n_j;         // shift-up position
    logic [IDX_W-1:0]     r_split, n_split; // entry being split
    t_range               r_sav, n_sav;     // range being split
    logic                 r_ovf, n_ovf;
    logic                 r_ent_valid, n_ent_valid;

    // result register
    logic                 r_out_valid, n_out_valid;
    logic [CNT_W-1:0]     r_o_count, n_o_count;
    logic                 r_o_ent_valid, n_o_ent_valid;
    logic [ADDR_BITS-1:0] r_o_start, n_o_start;
    logic [ADDR_BITS-1:0] r_o_end, n_o_end;
    logic                 r_o_ovf, n_o_ovf;

    // RAM port
    logic                 ram_we, ram_re;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    t_range               ram_wdata, ram_rdata;

    // walk classification of the entry just read
    logic ev_cover, ev_lotrim, ev_hitrim, ev_split;
    logic ev_last;

    frls_ram #(
        .WIDTH ($bits(t_range)),
        .DEPTH (MAX_RANGES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ev_cover  = (r_gs <= ram_rdata.lo) && (r_ge >= ram_rdata.hi);
    assign ev_lotrim = (r_gs <= ram_rdata.lo) && (r_ge >= ram_rdata.lo);
    assign ev_hitrim = (r_gs <= ram_rdata.hi) && (r_ge >= ram_rdata.hi);
    assign ev_split  = (r_gs > ram_rdata.lo) && (r_ge < ram_rdata.hi);
    assign ev_last   = (CNT_W'(r_rd) + CNT_W'(1)) == r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_region_lo <= '0;
            r_region_hi <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_region_lo <= n_region_lo;
            r_region_hi <= n_region_hi;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_gs          <= n_gs;
        r_ge          <= n_ge;
        r_idx         <= n_idx;
        r_rd          <= n_rd;
        r_wr          <= n_wr;
        r_j           <= n_j;
        r_split       <= n_split;
        r_sav         <= n_sav;
        r_ovf         <= n_ovf;
        r_ent_valid   <= n_ent_valid;
        r_o_count     <= n_o_count;
        r_o_ent_valid <= n_o_ent_valid;
        r_o_start     <= n_o_start;
        r_o_end       <= n_o_end;
        r_o_ovf       <= n_o_ovf;
    end

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_gs          = r_gs;
        n_ge          = r_ge;
        n_idx         = r_idx;
        n_region_lo   = r_region_lo;
        n_region_hi   = r_region_hi;
        n_count       = r_count;
        n_rd          = r_rd;
        n_wr          = r_wr;
        n_j           = r_j;
        n_split       = r_split;
        n_sav         = r_sav;
        n_ovf         = r_ovf;
        n_ent_valid   = r_ent_valid;
        n_o_count     = r_o_count;
        n_o_ent_valid = r_o_ent_valid;
        n_o_start     = r_o_start;
        n_o_end       = r_o_end;
        n_o_ovf       = r_o_ovf;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = r_wr[IDX_W-1:0];
        ram_raddr     = r_rd;
        ram_wdata     = ram_rdata;

        // drop the held result once taken
        n_out_valid = r_out_valid && i_stall;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd       = i_cmd;
                    n_idx       = i_entry_index;
                    n_ovf       = 1'b0;
                    n_ent_valid = 1'b0;
                    if (i_cmd == CMD_INIT) begin
                        n_region_lo = i_gap_start;
                        n_region_hi = i_gap_end;
                        n_gs        = i_gap_start;
                        n_ge        = i_gap_end;
                    end else begin
                        // clamp the gap to the region
                        n_gs = (i_gap_start < r_region_lo) ? r_region_lo : i_gap_start;
                        n_ge = (i_gap_end > r_region_hi) ? r_region_hi : i_gap_end;
                    end
                    n_state = S_CHECK;
                end
            end

            S_CHECK: begin
                case (r_cmd)
                    CMD_INIT: begin
                        if (r_gs <= r_ge) begin
                            ram_we       = 1'b1;
                            ram_waddr    = '0;
                            ram_wdata.lo = r_gs;
                            ram_wdata.hi = r_ge;
                            n_count      = CNT_W'(1);
                        end else begin
                            n_count = '0;
                        end
                        n_state = S_DONE;
                    end
                    CMD_SUB: begin
                        if ((r_gs > r_ge) || (r_count == '0)) begin
                            n_state = S_DONE;
                        end else begin
                            n_rd    = '0;
                            n_wr    = '0;
                            n_state = S_RD;
                        end
                    end
                    CMD_READ: begin
                        if (CNT_W'(r_idx) < r_count) begin
                            ram_re      = 1'b1;
                            ram_raddr   = r_idx;
                            n_ent_valid = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_rd;
                n_state   = S_EV;
            end

            S_EV: begin
                if (!ev_cover && !ev_lotrim && !ev_hitrim && ev_split) begin
                    // gap strictly inside this range: nothing before it changed
                    if (r_count == CNT_W'(MAX_RANGES)) begin
                        n_ovf   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_split = r_rd;
                        n_sav   = ram_rdata;
                        if (r_count > (CNT_W'(r_rd) + CNT_W'(1))) begin
                            n_j     = IDX_W'(r_count - CNT_W'(1));
                            n_state = S_SH_RD;
                        end else begin
                            n_state = S_SPL_LO;
                        end
                    end
                end else begin
                    // compact: keep or trim the entry, drop it when covered
                    if (!ev_cover) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_wr[IDX_W-1:0];
                        ram_wdata = ram_rdata;
                        if (ev_lotrim) begin
                            ram_wdata.lo = r_ge + ADDR_BITS'(1);
                        end else if (ev_hitrim) begin
                            ram_wdata.hi = r_gs - ADDR_BITS'(1);
                        end
                        n_wr = r_wr + CNT_W'(1);
                    end
                    if (ev_last) begin
                        n_count = n_wr;
                        n_state = S_DONE;
                    end else begin
                        n_rd    = r_rd + IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end

            S_SH_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_j;
                n_state   = S_SH_WR;
            end

            S_SH_WR: begin
                // move one entry up to open the slot after the split
                ram_we    = 1'b1;
                ram_waddr = r_j + IDX_W'(1);
                ram_wdata = ram_rdata;
                if (r_j == (r_split + IDX_W'(1))) begin
                    n_state = S_SPL_LO;
                end else begin
                    n_j     = r_j - IDX_W'(1);
                    n_state = S_SH_RD;
                end
            end

            S_SPL_LO: begin
                ram_we       = 1'b1;
                ram_waddr    = r_split;
                ram_wdata.lo = r_sav.lo;
                ram_wdata.hi = r_gs - ADDR_BITS'(1);
                n_state      = S_SPL_HI;
            end

            S_SPL_HI: begin
                ram_we       = 1'b1;
                ram_waddr    = r_split + IDX_W'(1);
                ram_wdata.lo = r_ge + ADDR_BITS'(1);
                ram_wdata.hi = r_sav.hi;
                n_count      = r_count + CNT_W'(1);
                n_state      = S_DONE;
            end

            S_DONE: begin
                // hand over once the result register is free
                if (!r_out_valid || !i_stall) begin
                    n_out_valid   = 1'b1;
                    n_o_count     = r_count;
                    n_o_ovf       = r_ovf;
                    n_o_ent_valid = (r_cmd == CMD_READ) && r_ent_valid;
                    if ((r_cmd == CMD_READ) && r_ent_valid) begin
                        n_o_start = ram_rdata.lo;
                        n_o_end   = ram_rdata.hi;
                    end else begin
                        n_o_start = '0;
                        n_o_end   = '0;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_range_count = r_o_count;
    assign o_entry_valid = r_o_ent_valid;
    assign o_entry_start = r_o_start;
    assign o_entry_end   = r_o_end;
    assign o_overflow    = r_o_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RANGES))
        else $error("range count above capacity");

    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("RAM read and write in the same cycle");

    a_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV) |-> (r_wr <= CNT_W'(r_rd)))
        else $error("compaction write overtook read position");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_range_count == CNT_W'(MAX_RANGES)))
        else $error("overflow reported with room in the list");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_stall) |=> (r_state == S_DONE))
        else $error("result dropped while output register was full");

endmodule
